@@ hw/rtl/ttg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttg_pkg: shared constants of the triangle tangent generator
// Widths of the edge/UV deltas, the shared multiplier and the accumulator.
// ----------------------------------------------------------------------------
package ttg_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DeltaW = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DeltaW;
  localparam int unsigned AccW   = ProdW + 1;
  localparam int unsigned OutW   = 16;
  localparam logic [OutW-1:0] OneQ14 = 16'd16384;

endpackage

`default_nettype wire

@@ hw/rtl/ttg_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttg_mul: shared signed multiplier
// One signed delta-width multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module ttg_mul import ttg_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic signed [DeltaW-1:0] a_i,
  input  wire logic signed [DeltaW-1:0] b_i,
  output      logic signed [ProdW-1:0]  p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ hw/rtl/triangle_tangent_generator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_generator_unit: per-triangle unit tangent from UV deltas
// The first two vertices of a triangle are stored as they arrive. The third
// vertex starts a sequencer around one shared multiplier and one wide adder:
// eight products form the UV determinant and raw tangent, a one-bit-per-cycle
// shifter normalizes, three squares sum the length, and a 32-step root and
// three restoring divisions finish. A degenerate triangle skips from the sign
// check to the result. The sequencer also waits for the previous triangle's
// three result items to drain before it hands over the new result.
// The input is stalled while the sequencer runs. Reset clears the vertex phase,
// the sequencer and the output count; the held vertices are not reset.
// ----------------------------------------------------------------------------
module triangle_tangent_generator_unit import ttg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [CoordW-1:0] pos_x_i,
  input  wire logic [CoordW-1:0] pos_y_i,
  input  wire logic [CoordW-1:0] pos_z_i,
  input  wire logic [CoordW-1:0] tex_u_i,
  input  wire logic [CoordW-1:0] tex_v_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [OutW-1:0]   tangent_x_o,
  output      logic [OutW-1:0]   tangent_y_o,
  output      logic [OutW-1:0]   tangent_z_o,
  output      logic              degenerate_o,
  output      logic              last_of_triangle_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SIGN, ST_NORM, ST_SQRT, ST_DIV, ST_DONE
  } state_e;

  // Multiplier operations in issue order. The A/B pairs form a - b.
  typedef enum logic [3:0] {
    OP_DET_A, OP_DET_B, OP_TX_A, OP_TX_B, OP_TY_A, OP_TY_B,
    OP_TZ_A, OP_TZ_B, OP_SQ_X, OP_SQ_Y, OP_SQ_Z
  } op_e;

  state_e state_q;
  op_e    op_q;
  logic   sub_q;
  logic [1:0] phase_q;

  logic [CoordW-1:0] pos_q [6];
  logic [CoordW-1:0] tex_q [4];

  logic signed [DeltaW-1:0] e1_q [3];
  logic signed [DeltaW-1:0] e2_q [3];
  logic signed [DeltaW-1:0] d1u_q, d1v_q, d2u_q, d2v_q;

  logic signed [AccW-1:0] acc_q, det_q;
  logic signed [AccW-1:0] t_q [3];
  logic        [AccW-1:0] mag_q [3];
  logic                   neg_q [3];

  logic [63:0] sum_q, root_q;
  logic [4:0]  sqrt_i_q;
  logic [DeltaW-1:0] len_q;
  logic [47:0] rem_q;
  logic [3:0]  div_i_q;
  logic [1:0]  comp_q;
  logic [14:0] quo_q;
  logic [OutW-1:0] qv_q [3];
  logic        degen_q;

  logic [1:0]      outcnt_q;
  logic [OutW-1:0] tx_q, ty_q, tz_q;
  logic            deg_out_q;

  logic signed [DeltaW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0]  prod;

  ttg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = d1u_q;
    mul_b = d2v_q;
    unique case (op_q)
      OP_DET_A: begin mul_a = d1u_q; mul_b = d2v_q;    end
      OP_DET_B: begin mul_a = d2u_q; mul_b = d1v_q;    end
      OP_TX_A:  begin mul_a = d2v_q; mul_b = e1_q[0];  end
      OP_TX_B:  begin mul_a = d1v_q; mul_b = e2_q[0];  end
      OP_TY_A:  begin mul_a = d2v_q; mul_b = e1_q[1];  end
      OP_TY_B:  begin mul_a = d1v_q; mul_b = e2_q[1];  end
      OP_TZ_A:  begin mul_a = d2v_q; mul_b = e1_q[2];  end
      OP_TZ_B:  begin mul_a = d1v_q; mul_b = e2_q[2];  end
      OP_SQ_X: begin
        mul_a = $signed({2'b00, mag_q[0][30:0]});
        mul_b = $signed({2'b00, mag_q[0][30:0]});
      end
      OP_SQ_Y: begin
        mul_a = $signed({2'b00, mag_q[1][30:0]});
        mul_b = $signed({2'b00, mag_q[1][30:0]});
      end
      OP_SQ_Z: begin
        mul_a = $signed({2'b00, mag_q[2][30:0]});
        mul_b = $signed({2'b00, mag_q[2][30:0]});
      end
      default: begin mul_a = d1u_q; mul_b = d2v_q; end
    endcase
  end

  // Shared adder paths.
  logic signed [AccW-1:0] pext, diff;
  assign pext = {prod[ProdW-1], prod};
  assign diff = acc_q - pext;

  // Sign fix-up of the raw tangent.
  logic signed [AccW-1:0] tv [3];
  logic [AccW-1:0] tmag [3];
  logic tneg [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tv[k]   = det_q[AccW-1] ? -t_q[k] : t_q[k];
      tneg[k] = tv[k][AccW-1];
      tmag[k] = tneg[k] ? AccW'(-tv[k]) : AccW'(tv[k]);
    end
  end

  logic [AccW-1:0] any_mag;
  assign any_mag = mag_q[0] | mag_q[1] | mag_q[2];

  // One step of the integer square root.
  logic [63:0] sq_bit, sq_trial, root_next;
  logic        sq_ge;
  assign sq_bit    = 64'd1 << {sqrt_i_q, 1'b0};
  assign sq_trial  = root_q + sq_bit;
  assign sq_ge     = sum_q >= sq_trial;
  assign root_next = sq_ge ? ((root_q >> 1) + sq_bit) : (root_q >> 1);

  // One step of the restoring division.
  logic [47:0] dv_trial;
  logic        dv_ge;
  logic [14:0] quo_next;
  logic [OutW-1:0] dv_clamp;
  assign dv_trial = {15'd0, len_q} << div_i_q;
  assign dv_ge    = rem_q >= dv_trial;
  assign quo_next = {quo_q[13:0], dv_ge};
  assign dv_clamp = ({1'b0, quo_next} > OneQ14) ? OneQ14 : {1'b0, quo_next};

  logic out_take;
  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_DET_A;
      sub_q    <= 1'b0;
      phase_q  <= 2'd0;
      outcnt_q <= 2'd0;
    end else begin
      if (out_take) begin
        outcnt_q <= outcnt_q - 2'd1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (phase_q == 2'd1) begin
              pos_q[3] <= pos_x_i;
              pos_q[4] <= pos_y_i;
              pos_q[5] <= pos_z_i;
              tex_q[2] <= tex_u_i;
              tex_q[3] <= tex_v_i;
              phase_q  <= 2'd2;
            end else if (phase_q == 2'd2) begin
              e1_q[0] <= {pos_q[3][31], pos_q[3]} - {pos_q[0][31], pos_q[0]};
              e1_q[1] <= {pos_q[4][31], pos_q[4]} - {pos_q[1][31], pos_q[1]};
              e1_q[2] <= {pos_q[5][31], pos_q[5]} - {pos_q[2][31], pos_q[2]};
              e2_q[0] <= {pos_x_i[31], pos_x_i} - {pos_q[0][31], pos_q[0]};
              e2_q[1] <= {pos_y_i[31], pos_y_i} - {pos_q[1][31], pos_q[1]};
              e2_q[2] <= {pos_z_i[31], pos_z_i} - {pos_q[2][31], pos_q[2]};
              d1u_q   <= {tex_q[2][31], tex_q[2]} - {tex_q[0][31], tex_q[0]};
              d1v_q   <= {tex_q[3][31], tex_q[3]} - {tex_q[1][31], tex_q[1]};
              d2u_q   <= {tex_u_i[31], tex_u_i} - {tex_q[0][31], tex_q[0]};
              d2v_q   <= {tex_v_i[31], tex_v_i} - {tex_q[1][31], tex_q[1]};
              phase_q <= 2'd0;
              degen_q <= 1'b0;
              op_q    <= OP_DET_A;
              sub_q   <= 1'b0;
              state_q <= ST_MUL;
            end else begin
              // First vertex; an out-of-range phase is treated the same way.
              pos_q[0] <= pos_x_i;
              pos_q[1] <= pos_y_i;
              pos_q[2] <= pos_z_i;
              tex_q[0] <= tex_u_i;
              tex_q[1] <= tex_v_i;
              phase_q  <= 2'd1;
            end
          end
        end

        ST_MUL: begin
          sub_q <= !sub_q;
          if (sub_q) begin
            case (op_q) inside
              OP_DET_A, OP_TX_A, OP_TY_A, OP_TZ_A: acc_q <= pext;
              OP_DET_B: det_q  <= diff;
              OP_TX_B:  t_q[0] <= diff;
              OP_TY_B:  t_q[1] <= diff;
              OP_TZ_B:  t_q[2] <= diff;
              default:  sum_q  <= sum_q + prod[63:0];
            endcase
            if (op_q == OP_TZ_B) begin
              state_q <= ST_SIGN;
            end else if (op_q == OP_SQ_Z) begin
              root_q   <= 64'd0;
              sqrt_i_q <= 5'd31;
              state_q  <= ST_SQRT;
            end else begin
              op_q <= op_e'(op_q + 4'd1);
            end
          end
        end

        ST_SIGN: begin
          if (det_q == '0 || (t_q[0] == '0 && t_q[1] == '0 && t_q[2] == '0)) begin
            degen_q <= 1'b1;
            qv_q[0] <= '0;
            qv_q[1] <= '0;
            qv_q[2] <= '0;
            state_q <= ST_DONE;
          end else begin
            for (int k = 0; k < 3; k++) begin
              mag_q[k] <= tmag[k];
              neg_q[k] <= tneg[k];
            end
            state_q <= ST_NORM;
          end
        end

        ST_NORM: begin
          // Bring the largest magnitude into [2^30, 2^31) one bit at a time.
          if (|any_mag[AccW-1:31]) begin
            for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
          end else if (!any_mag[30]) begin
            for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
          end else begin
            sum_q   <= 64'd0;
            op_q    <= OP_SQ_X;
            sub_q   <= 1'b0;
            state_q <= ST_MUL;
          end
        end

        ST_SQRT: begin
          if (sq_ge) begin
            sum_q <= sum_q - sq_trial;
          end
          root_q   <= root_next;
          sqrt_i_q <= sqrt_i_q - 5'd1;
          if (sqrt_i_q == 5'd0) begin
            len_q   <= root_next[DeltaW-1:0];
            comp_q  <= 2'd0;
            div_i_q <= 4'd15;
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_i_q == 4'd15) begin
            // Load the rounded numerator of the current component.
            rem_q   <= ({17'd0, mag_q[comp_q][30:0]} << 14) + {16'd0, len_q[DeltaW-1:1]};
            quo_q   <= '0;
            div_i_q <= 4'd14;
          end else begin
            if (dv_ge) begin
              rem_q <= rem_q - dv_trial;
            end
            quo_q   <= quo_next;
            div_i_q <= div_i_q - 4'd1;
            if (div_i_q == 4'd0) begin
              qv_q[comp_q] <= neg_q[comp_q] ? (OutW'(0) - dv_clamp) : dv_clamp;
              if (comp_q == 2'd2) begin
                state_q <= ST_DONE;
              end else begin
                comp_q  <= comp_q + 2'd1;
                div_i_q <= 4'd15;
              end
            end
          end
        end

        ST_DONE: begin
          if (outcnt_q == 2'd0) begin
            tx_q      <= qv_q[0];
            ty_q      <= qv_q[1];
            tz_q      <= qv_q[2];
            deg_out_q <= degen_q;
            outcnt_q  <= 2'd3;
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = (outcnt_q != 2'd0);
  assign tangent_x_o        = tx_q;
  assign tangent_y_o        = ty_q;
  assign tangent_z_o        = tz_q;
  assign degenerate_o       = deg_out_q;
  assign last_of_triangle_o = (outcnt_q == 2'd1);

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for triangle_tangent_generator_unit
// Streams vertices into the block, predicts the three tangent result items
// of each triangle with an exact integer model and compares every field.
// ----------------------------------------------------------------------------
module tb_top;
  import ttg_pkg::*;

  // One vertex item as offered to the block. Rows of the directed table may
  // carry a hand-written tangent that replaces the predicted one.
  typedef struct {
    logic [CoordW-1:0] px, py, pz, tu, tv;
    bit                typed;
    logic [OutW-1:0]   ex, ey, ez;
    bit                edeg;
  } vertex_t;

  // One result item of the block.
  typedef struct {
    logic [OutW-1:0] tx, ty, tz;
    logic            deg;
    logic            last;
  } tangent_t;

  localparam logic [CoordW-1:0] QOne = 32'h0001_0000;
  localparam logic [CoordW-1:0] CMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] CMin = 32'h8000_0000;
  localparam int RandTriangles = 136;
  localparam int HoldCycles    = 700;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CoordW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [CoordW-1:0] tex_u_i = '0, tex_v_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [OutW-1:0]   tangent_x_o, tangent_y_o, tangent_z_o;
  logic              degenerate_o, last_of_triangle_o;

  triangle_tangent_generator_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_u_i, .tex_v_i,
    .out_valid_o, .out_stall_i,
    .tangent_x_o, .tangent_y_o, .tangent_z_o,
    .degenerate_o, .last_of_triangle_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vertex_t  vertex_q[$];
  tangent_t tangent_expected_q[$];
  int       mismatches = 0;
  bit       sender_done = 1'b0;
  int       taken = 0;

  // Vertices 0 and 1 of the triangle being collected, and the vertex index.
  logic [CoordW-1:0] held_pos[6];
  logic [CoordW-1:0] held_tex[4];
  int                vertex_phase = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Exact tangent of one triangle: deltas are 33 bits, products and sums are
  // carried at 68 bits, then the vector is normalized to 31-bit magnitudes.
  function automatic tangent_t predict_tangent(input logic [CoordW-1:0] p[9],
                                               input logic [CoordW-1:0] uv[6]);
    tangent_t          r;
    logic signed [32:0] e1[3], e2[3];
    logic signed [32:0] d1u, d1v, d2u, d2v;
    logic signed [67:0] det, t;
    logic [67:0]        mag[3], any;
    bit                 ng[3];
    int                 bl;
    logic [63:0]        m[3], sum, len, v;
    r = '{default: '0};
    for (int k = 0; k < 3; k++) begin
      e1[k] = $signed({p[3+k][31], p[3+k]}) - $signed({p[k][31], p[k]});
      e2[k] = $signed({p[6+k][31], p[6+k]}) - $signed({p[k][31], p[k]});
    end
    d1u = $signed({uv[2][31], uv[2]}) - $signed({uv[0][31], uv[0]});
    d1v = $signed({uv[3][31], uv[3]}) - $signed({uv[1][31], uv[1]});
    d2u = $signed({uv[4][31], uv[4]}) - $signed({uv[0][31], uv[0]});
    d2v = $signed({uv[5][31], uv[5]}) - $signed({uv[1][31], uv[1]});
    det = 68'(d1u) * 68'(d2v) - 68'(d2u) * 68'(d1v);
    r.deg = 1'b1;
    if (det == 0) return r;
    any = '0;
    for (int k = 0; k < 3; k++) begin
      t = 68'(d2v) * 68'(e1[k]) - 68'(d1v) * 68'(e2[k]);
      if (det < 0) t = -t;
      ng[k] = t < 0;
      mag[k] = ng[k] ? -t : t;
      any |= mag[k];
    end
    if (any == 0) return r;
    bl = 0;
    for (int b = 0; b < 68; b++) if (any[b]) bl = b + 1;
    for (int k = 0; k < 3; k++) begin
      if (bl > 31) m[k] = 64'(mag[k] >> (bl - 31));
      else         m[k] = 64'(mag[k] << (31 - bl));
      m[k] &= 64'h7FFF_FFFF;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    if (len == 0) return r;
    r.deg = 1'b0;
    for (int k = 0; k < 3; k++) begin
      v = (m[k] * 64'(OneQ14) + len / 2) / len;
      if (v > 64'(OneQ14)) v = 64'(OneQ14);
      v = ng[k] ? (64'h10000 - v) & 64'hFFFF : v;
      if (k == 0) r.tx = v[15:0];
      else if (k == 1) r.ty = v[15:0];
      else r.tz = v[15:0];
    end
    return r;
  endfunction

  // Track every accepted vertex; on the third one queue three result items.
  always @(posedge clk_i) begin
    logic [CoordW-1:0] p[9];
    logic [CoordW-1:0] uv[6];
    vertex_t           vx;
    tangent_t          tg;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      vx = vertex_q[taken];
      taken++;
      if (vertex_phase < 2) begin
        held_pos[vertex_phase*3]   = pos_x_i;
        held_pos[vertex_phase*3+1] = pos_y_i;
        held_pos[vertex_phase*3+2] = pos_z_i;
        held_tex[vertex_phase*2]   = tex_u_i;
        held_tex[vertex_phase*2+1] = tex_v_i;
        vertex_phase++;
      end else begin
        for (int k = 0; k < 6; k++) p[k] = held_pos[k];
        for (int k = 0; k < 4; k++) uv[k] = held_tex[k];
        p[6] = pos_x_i; p[7] = pos_y_i; p[8] = pos_z_i;
        uv[4] = tex_u_i; uv[5] = tex_v_i;
        if (vx.typed) tg = '{tx: vx.ex, ty: vx.ey, tz: vx.ez, deg: vx.edeg, last: 1'b0};
        else          tg = predict_tangent(p, uv);
        for (int r = 0; r < 3; r++) begin
          tg.last = (r == 2);
          tangent_expected_q = {tangent_expected_q, tg};
        end
        vertex_phase = 0;
      end
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk_i) begin
    tangent_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tangent_expected_q.size() == 0) begin
        report("unexpected result item", 32'(tangent_x_o), 32'd0);
      end else begin
        want = tangent_expected_q.pop_front();
        if (tangent_x_o !== want.tx) report("tangent_x", 32'(tangent_x_o), 32'(want.tx));
        if (tangent_y_o !== want.ty) report("tangent_y", 32'(tangent_y_o), 32'(want.ty));
        if (tangent_z_o !== want.tz) report("tangent_z", 32'(tangent_z_o), 32'(want.tz));
        if (degenerate_o !== want.deg) report("degenerate", 32'(degenerate_o), 32'(want.deg));
        if (last_of_triangle_o !== want.last)
          report("last_of_triangle", 32'(last_of_triangle_o), 32'(want.last));
      end
    end
  end

  function automatic void add_vtx(input logic [31:0] x, y, z, u, v);
    vertex_t vt;
    vt = '{px: x, py: y, pz: z, tu: u, tv: v, typed: 1'b0,
           ex: '0, ey: '0, ez: '0, edeg: 1'b0};
    vertex_q = {vertex_q, vt};
  endfunction

  // Third vertex whose tangent is obvious from the geometry.
  function automatic void add_known(input logic [31:0] x, y, z, u, v,
                                    input logic [15:0] ex, ey, ez, input bit dg);
    vertex_t vt;
    vt = '{px: x, py: y, pz: z, tu: u, tv: v, typed: 1'b1,
           ex: ex, ey: ey, ez: ez, edeg: dg};
    vertex_q = {vertex_q, vt};
  endfunction

  // Coordinate of a given flavor: full range, small around zero, or an extreme.
  function automatic logic [31:0] rand_coord(input int flavor);
    case (flavor)
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
      default: return $urandom_range(0, 1) ? CMax : CMin;
    endcase
  endfunction

  function automatic void add_random_triangle();
    int          kind, fl;
    logic [31:0] c[15];
    kind = $urandom_range(0, 9);
    fl = (kind < 4) ? 0 : (kind < 8) ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 1);
    for (int k = 0; k < 15; k++) c[k] = rand_coord($urandom_range(0, 7) == 0 ? 2 : fl);
    if (kind == 8) begin
      // Repeated texture coordinate: zero UV determinant.
      c[8] = c[3]; c[9] = c[4];
    end else if (kind == 9) begin
      // Repeated position: one edge vanishes.
      c[10] = c[0]; c[11] = c[1]; c[12] = c[2];
    end
    for (int i = 0; i < 3; i++) add_vtx(c[i*5], c[i*5+1], c[i*5+2], c[i*5+3], c[i*5+4]);
  endfunction

  // Sender: items go out in bursts separated by random gaps.
  initial begin
    vertex_t vx;
    int      burst;
    // Unit edges along x and y with matching texture axes: tangent is +x.
    add_vtx(0, 0, 0, 0, 0);
    add_vtx(QOne, 0, 0, QOne, 0);
    add_known(0, QOne, 0, 0, QOne, OneQ14, 16'd0, 16'd0, 1'b0);
    // Swapped texture axes: negative determinant flips the tangent to +y.
    add_vtx(0, 0, 0, 0, 0);
    add_vtx(QOne, 0, 0, 0, QOne);
    add_known(0, QOne, 0, QOne, 0, 16'd0, OneQ14, 16'd0, 1'b0);
    // All texture coordinates equal: zero determinant.
    add_vtx(0, 0, 0, QOne, QOne);
    add_vtx(QOne, QOne, 0, QOne, QOne);
    add_known(CMax, CMin, QOne, QOne, QOne, 16'd0, 16'd0, 16'd0, 1'b1);
    // Valid texture mapping on a collapsed triangle: zero tangent vector.
    add_vtx(QOne, QOne, QOne, 0, 0);
    add_vtx(QOne, QOne, QOne, QOne, 0);
    add_known(QOne, QOne, QOne, 0, QOne, 16'd0, 16'd0, 16'd0, 1'b1);
    // Extremes of every field.
    add_vtx(CMin, CMin, CMin, CMin, CMin);
    add_vtx(CMax, CMax, CMax, CMax, CMin);
    add_vtx(CMin, CMax, CMin, CMin, CMax);
    add_vtx(CMax, CMin, CMax, CMax, CMax);
    add_vtx(CMin, CMax, CMin, CMin, CMin);
    add_vtx(CMax, CMax, CMin, CMax, CMin);
    add_vtx(CMin, CMin, CMin, CMin, CMin);
    add_vtx(CMin, CMin, CMin, CMin, CMin);
    add_known(CMin, CMin, CMin, CMin, CMin, 16'd0, 16'd0, 16'd0, 1'b1);
    for (int i = 0; i < RandTriangles; i++) add_random_triangle();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst = 0;
    for (int i = 0; i < vertex_q.size(); i++) begin
      vx = vertex_q[i];
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b1;
      pos_x_i <= vx.px; pos_y_i <= vx.py; pos_z_i <= vx.pz;
      tex_u_i <= vx.tu; tex_v_i <= vx.tv;
      do @(posedge clk_i); while (in_stall_o);
      burst--;
    end
    in_valid_i <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random stall pattern with quiet stretches, and one long hold
  // while the sender keeps offering so that the block backs up its input.
  initial begin
    int cyc, mode;
    cyc = 0;
    mode = 0;
    while (1) begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 500 == 0) mode = $urandom_range(0, 3);
      if (cyc >= 4000 && cyc < 4000 + HoldCycles) out_stall_i <= 1'b1;
      else if (mode == 0) out_stall_i <= 1'b0;
      else if (mode == 1) out_stall_i <= ($urandom_range(0, 3) == 0);
      else if (mode == 2) out_stall_i <= ($urandom_range(0, 1) == 0);
      else out_stall_i <= ((cyc % 7) < 2);
    end
  end

  // Ending: drain the expected results, then allow the block's latency.
  initial begin
    wait (sender_done);
    while (tangent_expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && tangent_expected_q.size() == 0) begin
      $display("** triangle_tangent_generator_unit: PASSED **");
    end else begin
      $display("** triangle_tangent_generator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** triangle_tangent_generator_unit: FAILED **");
    $finish;
  end

endmodule
